// ===== rtl/core/mfud_pkg.sv =====
// Shared constants, types and saturating helpers for the metric normalize core.
`default_nettype none
package mfud_pkg;
	localparam int WORD_BITS  = 48;
	localparam int FRAC_BITS  = 40;
	localparam int HALF_BITS  = WORD_BITS / 2;
	localparam int FLOOR_BITS = WORD_BITS - 1;
	localparam int CB_STEPS   = WORD_BITS - 1;
	localparam int RW         = 4 * WORD_BITS + 20;
	localparam int DET_STG    = 7;
	localparam int LAT        = DET_STG + CB_STEPS + 2;
	localparam int NUM_M      = 6;

	localparam int M_XX = 0;
	localparam int M_XY = 1;
	localparam int M_XZ = 2;
	localparam int M_YY = 3;
	localparam int M_YZ = 4;
	localparam int M_ZZ = 5;

	localparam int REG_W_FLOOR     = 0;
	localparam int REG_ALPHA_FLOOR = 1;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t                w;
		word_t                lapse;
		logic [NUM_M-1:0][WORD_BITS-1:0] m;
	} side_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WMIN : WMAX;
		end
		return s[WORD_BITS-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WMIN : WMAX;
		end
		return s[WORD_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mfud_mulq.sv =====
// Two-stage rounded, saturating fixed-point multiplier built from half-word partial products.
`default_nettype none
module mfud_mulq (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire mfud_pkg::word_t     a,
	input  wire mfud_pkg::word_t     b,
	output mfud_pkg::word_t          p
);
	localparam int W = mfud_pkg::WORD_BITS;
	localparam int H = mfud_pkg::HALF_BITS;
	localparam int F = mfud_pkg::FRAC_BITS;

	logic [W-1:0] ma, mb;
	logic         neg_s1;
	logic [W-1:0] pp0_s1, pp1_s1, pp2_s1, pp3_s1;
	logic [2*W:0] prod, sum;
	logic [2*W-F:0] q;
	logic [2*W:0] rnd;

	always_comb begin
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[W-1] ^ b[W-1];
			pp0_s1 <= ma[H-1:0] * mb[H-1:0];
			pp1_s1 <= ma[H-1:0] * mb[W-1:H];
			pp2_s1 <= ma[W-1:H] * mb[H-1:0];
			pp3_s1 <= ma[W-1:H] * mb[W-1:H];
		end
	end

	// Ties round toward plus infinity, so a negative result rounds with one less.
	always_comb begin
		prod = ((2*W+1)'(pp3_s1) << (2*H)) + ((2*W+1)'(pp1_s1) << H)
			+ ((2*W+1)'(pp2_s1) << H) + (2*W+1)'(pp0_s1);
		rnd = neg_s1 ? (((2*W+1)'(1) << (F-1)) - (2*W+1)'(1)) : ((2*W+1)'(1) << (F-1));
		sum = prod + rnd;
		q = sum[2*W:F];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s1) begin
				p <= (q > (2*W-F+1)'(mfud_pkg::WMAX)) ? mfud_pkg::WMAX : W'(q);
			end else begin
				p <= (q > ((2*W-F+1)'(1) << (W-1))) ? mfud_pkg::WMIN : W'(-q);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/mfud_icbrt.sv =====
// Pipelined bit-by-bit inverse cube root: one result bit per register stage.
`default_nettype none
module mfud_icbrt (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [mfud_pkg::FLOOR_BITS-1:0]   det,
	output mfud_pkg::word_t                        chi
);
	localparam int N  = mfud_pkg::CB_STEPS;
	localparam int RW = mfud_pkg::RW;
	localparam int F  = mfud_pkg::FRAC_BITS;

	// Per stage: partial root, remainder 2^(4F) - c^3*det, det*c^2, det*c, det.
	// The last stage only needs to keep the root.
	logic [N-1:0]  c_s [1:N];
	logic [RW-1:0] r_s [1:N-1];
	logic [RW-1:0] a_s [1:N-1];
	logic [RW-1:0] b_s [1:N-1];
	logic [RW-1:0] d_s [1:N-1];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int BIT = N - 1 - k;
		logic [N-1:0]  c_in;
		logic [RW-1:0] r_in, a_in, b_in, d_in;
		logic [RW-1:0] delta;
		logic          take;

		if (k == 0) begin : g_first
			assign c_in = '0;
			assign r_in = RW'(1) << (4*F);
			assign a_in = '0;
			assign b_in = '0;
			assign d_in = RW'(det);
		end else begin : g_next
			assign c_in = c_s[k];
			assign r_in = r_s[k];
			assign a_in = a_s[k];
			assign b_in = b_s[k];
			assign d_in = d_s[k];
		end

		always_comb begin
			delta = ((a_in + (a_in << 1)) << BIT)
				+ ((b_in + (b_in << 1)) << (2*BIT))
				+ (d_in << (3*BIT));
			take = delta <= r_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[k+1] <= take ? (c_in | (N'(1) << BIT)) : c_in;
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					d_s[k+1] <= d_in;
					if (take) begin
						r_s[k+1] <= r_in - delta;
						a_s[k+1] <= a_in + (b_in << (BIT+1)) + (d_in << (2*BIT));
						b_s[k+1] <= b_in + (d_in << BIT);
					end else begin
						r_s[k+1] <= r_in;
						a_s[k+1] <= a_in;
						b_s[k+1] <= b_in;
					end
				end
			end
		end
	end

	assign chi = {1'b0, c_s[N]};
endmodule
`default_nettype wire

// ===== rtl/core/metric_floor_and_unit_det_normalize_core.sv =====
// Top level of the metric floor and unit-determinant normalize core.
// The block takes one grid point per transfer on the s_axis channel: the
// conformal factor, the lapse-like component and the six entries of a
// symmetric 3x3 metric, all signed Q8.40. It returns one result transfer per
// input on the m_axis channel: the floored factor, the floored lapse term,
// the metric scaled to unit determinant, and in tuser a flag that is set when
// the determinant was zero or negative (the metric then passes unchanged).
// The two floors are written over the APB port (w_floor at 0x0, alpha_floor
// at 0x8); the user must write them only while the block is idle, which the
// block does not enforce. Both reset to zero. One item is accepted every
// cycle while the output is not stalled. The inverse cube root resolves one
// bit of the 47-bit root per pipeline stage; the determinant uses a two-level
// multiply chain and the final scaling one multiply, each taking two stages.
// Reset clears all valid bits, so the pipeline comes up empty.
// The whole pipeline advances together: when the output register holds a
// result the receiver has not taken, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated.
`default_nettype none
module metric_floor_and_unit_det_normalize_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// w_in, lapse_comp_in, m_xx_in, m_xy_in, m_xz_in, m_yy_in, m_yz_in, m_zz_in
	input  wire logic [383:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// w_out, lapse_comp_out, m_xx_out, m_xy_out, m_xz_out, m_yy_out, m_yz_out, m_zz_out
	output logic      [383:0] m_axis_tdata,
	// det_invalid
	output logic              m_axis_tuser
);
	localparam int W   = mfud_pkg::WORD_BITS;
	localparam int FB  = mfud_pkg::FLOOR_BITS;
	localparam int LAT = mfud_pkg::LAT;
	localparam int DS  = mfud_pkg::DET_STG;
	localparam int NM  = mfud_pkg::NUM_M;

	logic [FB-1:0] w_floor_q, alpha_floor_q;
	logic          cfg_wr;
	logic          reg_idx;

	// Register file: the index is taken from the 8-byte slot of the address.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_floor_q     <= '0;
			alpha_floor_q <= '0;
		end else if (cfg_wr) begin
			if (reg_idx == 1'(mfud_pkg::REG_W_FLOOR)) begin
				w_floor_q <= pwdata[FB-1:0];
			end else begin
				alpha_floor_q <= pwdata[FB-1:0];
			end
		end
	end

	always_comb begin
		if (reg_idx == 1'(mfud_pkg::REG_W_FLOOR)) begin
			prdata = 64'(w_floor_q);
		end else begin
			prdata = 64'(alpha_floor_q);
		end
	end

	// Global pipeline advance.
	logic en;
	logic valid_s [1:LAT];
	mfud_pkg::side_t side_s [1:LAT];
	logic inv_s [DS:LAT];

	assign en            = !valid_s[LAT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= LAT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// Stage 1: floors. -2*alpha_floor may fall below the smallest word.
	mfud_pkg::word_t          w_in, lapse_in, wf, lfc;
	logic signed [W+1:0]      lf;
	mfud_pkg::side_t          side_in;

	always_comb begin
		w_in     = s_axis_tdata[W-1:0];
		lapse_in = s_axis_tdata[2*W-1:W];
		wf       = {1'b0, w_floor_q};
		lf       = -$signed({2'b00, alpha_floor_q, 1'b0});
		lfc      = (lf < (W+2)'(mfud_pkg::WMIN)) ? mfud_pkg::WMIN : lf[W-1:0];
		side_in.w     = (w_in < wf) ? wf : w_in;
		side_in.lapse = (lapse_in > lfc) ? lfc : lapse_in;
		for (int i = 0; i < NM; i++) begin
			side_in.m[i] = s_axis_tdata[(i+2)*W +: W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			for (int k = 2; k <= LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Stages 2-3: cofactor products.
	mfud_pkg::word_t m1 [0:NM-1];
	mfud_pkg::word_t p_yyzz, p_yzyz, p_xyzz, p_yzxz, p_xyyz, p_yyxz;

	always_comb begin
		for (int i = 0; i < NM; i++) begin
			m1[i] = side_s[1].m[i];
		end
	end

	mfud_mulq u_mul_yyzz (.clk, .en, .a(m1[mfud_pkg::M_YY]), .b(m1[mfud_pkg::M_ZZ]), .p(p_yyzz));
	mfud_mulq u_mul_yzyz (.clk, .en, .a(m1[mfud_pkg::M_YZ]), .b(m1[mfud_pkg::M_YZ]), .p(p_yzyz));
	mfud_mulq u_mul_xyzz (.clk, .en, .a(m1[mfud_pkg::M_XY]), .b(m1[mfud_pkg::M_ZZ]), .p(p_xyzz));
	mfud_mulq u_mul_yzxz (.clk, .en, .a(m1[mfud_pkg::M_YZ]), .b(m1[mfud_pkg::M_XZ]), .p(p_yzxz));
	mfud_mulq u_mul_xyyz (.clk, .en, .a(m1[mfud_pkg::M_XY]), .b(m1[mfud_pkg::M_YZ]), .p(p_xyyz));
	mfud_mulq u_mul_yyxz (.clk, .en, .a(m1[mfud_pkg::M_YY]), .b(m1[mfud_pkg::M_XZ]), .p(p_yyxz));

	// Stage 4: cofactors.
	mfud_pkg::word_t c0_s4, c1_s4, c2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s4 <= mfud_pkg::sat_sub(p_yyzz, p_yzyz);
			c1_s4 <= mfud_pkg::sat_sub(p_xyzz, p_yzxz);
			c2_s4 <= mfud_pkg::sat_sub(p_xyyz, p_yyxz);
		end
	end

	// Stages 5-6: cofactor expansion along the first row.
	mfud_pkg::word_t e0, e1, e2, det_s7;

	mfud_mulq u_mul_e0 (.clk, .en, .a(side_s[4].m[mfud_pkg::M_XX]), .b(c0_s4), .p(e0));
	mfud_mulq u_mul_e1 (.clk, .en, .a(side_s[4].m[mfud_pkg::M_XY]), .b(c1_s4), .p(e1));
	mfud_mulq u_mul_e2 (.clk, .en, .a(side_s[4].m[mfud_pkg::M_XZ]), .b(c2_s4), .p(e2));

	// Stage 7: determinant and the validity flag, which then travels with the item.
	mfud_pkg::word_t det_c;

	always_comb begin
		det_c = mfud_pkg::sat_add(mfud_pkg::sat_sub(e0, e1), e2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s7    <= det_c;
			inv_s[DS] <= (det_c <= 0);
			for (int k = DS+1; k <= LAT; k++) begin
				inv_s[k] <= inv_s[k-1];
			end
		end
	end

	// Stages 8-54: inverse cube root. An invalid determinant still flows
	// through, and its root is simply not used.
	mfud_pkg::word_t chi;

	mfud_icbrt u_icbrt (.clk, .en, .det(det_s7[FB-1:0]), .chi(chi));

	// Stages 55-56: scale each entry, or pass it when the determinant is bad.
	localparam int SC = DS + mfud_pkg::CB_STEPS;
	mfud_pkg::word_t scaled [0:NM-1];

	for (genvar i = 0; i < NM; i++) begin : g_scale
		mfud_mulq u_mul_scale (.clk, .en, .a(chi), .b(side_s[SC].m[i]), .p(scaled[i]));
	end

	always_comb begin
		m_axis_tdata[W-1:0]   = side_s[LAT].w;
		m_axis_tdata[2*W-1:W] = side_s[LAT].lapse;
		for (int i = 0; i < NM; i++) begin
			m_axis_tdata[(i+2)*W +: W] = inv_s[LAT] ? side_s[LAT].m[i] : scaled[i];
		end
		m_axis_tuser = inv_s[LAT];
	end
endmodule
`default_nettype wire
